@@ src/tncs_pkg.sv @@
// shared types and constants for the tactile node calibrate and scale block
`timescale 1ns / 1ps
package tncs_pkg;

    // field widths
    localparam int ACTION_W  = 3;
    localparam int NODE_W    = 10;
    localparam int SAMPLE_W  = 12;
    localparam int PKT_POS_W = 8;
    localparam int PKT_SZ_W  = 9;

    // wide product of a clipped offset and full scale
    localparam int PROD_W = 2 * SAMPLE_W;

    // node index zero-extended to the widest table address
    localparam int NODE_EXT_W = 12;

    // configuration port
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_CAL      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_NODES = 1'd1;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SCAN      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TRACK_MAX = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TRACK_MIN = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_MAX = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_MIN = 3'd4;

    // top of the scaled range, also the cleared min entry
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd3072;

    // largest packet size
    localparam logic [PKT_SZ_W-1:0] PKT_SZ_MAX = 9'd256;

    // input transaction
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   node_index;
        logic [SAMPLE_W-1:0] adc_reading;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [SAMPLE_W-1:0] pressure_value;
        logic                packet_first;
        logic                packet_last;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                in_range;
        logic [NODE_W-1:0]   node_index;
        logic [SAMPLE_W-1:0] adc_reading;
        logic                packet_first;
        logic                packet_last;
    } q_item_t;

endpackage

@@ src/tactile_node_calibrate_scale.sv @@
// Path: a calibrated scan with max above min goes from acceptance to m_valid through
// dequeue, table read, 12 divider steps and output load; every other item skips the divider.
// Back end: one item at a time, paced by the one-bit-per-cycle divider for calibrated
// scans; a new item is taken from the queue only after the last one is loaded for output.
// Reset: synchronous active-low; after release both tables are zeroed, one entry a cycle,
// and s_ready stays low until every entry has been cleared.
`timescale 1ns / 1ps
module tactile_node_calibrate_scale #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tncs_pkg::in_item_t                 s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tncs_pkg::out_item_t                m_payload,
    input  logic                               cfg_wr_en,
    input  logic [tncs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tncs_pkg::CFG_W-1:0]         cfg_wdata
);
    import tncs_pkg::*;

    logic                use_cal_reg;
    logic [PKT_SZ_W-1:0] packet_nodes_reg;
    logic                clear_busy;
    logic                q_push, q_pop, q_full, q_empty;
    q_item_t             q_data, q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_cal_reg      <= 1'b0;
            packet_nodes_reg <= PKT_SZ_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_USE_CAL:      use_cal_reg      <= cfg_wdata[0];
                CFG_PACKET_NODES: packet_nodes_reg <= cfg_wdata[PKT_SZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    tncs_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .packet_nodes (packet_nodes_reg),
        .clear_busy   (clear_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    // decoupling queue
    tncs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // back end
    tncs_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .use_calibration (use_cal_reg),
        .q_head          (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .clear_busy      (clear_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload)
    );

    // no transaction accepted while the tables are being cleared
    assert property (@(posedge aclk) disable iff (!aresetn) clear_busy |-> !s_ready)
        else $error("input accepted during table clear");

    // the queue is never written when full
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("queue overflow");

    // the queue is never read when empty
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("queue underflow");

    // once the clearing pass ends it does not come back without reset
    assert property (@(posedge aclk) disable iff (!aresetn) !clear_busy |=> !clear_busy)
        else $error("table clear restarted");

endmodule

@@ src/tncs_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tncs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tncs_front.sv @@
// front end: accepts readings, checks the node range and tracks packet position
`timescale 1ns / 1ps
module tncs_front #(
    parameter int NODE_COUNT = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tncs_pkg::in_item_t               s_payload,
    input  logic [tncs_pkg::PKT_SZ_W-1:0]    packet_nodes,
    input  logic                             clear_busy,
    input  logic                             q_full,
    output logic                             q_push,
    output tncs_pkg::q_item_t                q_data
);
    import tncs_pkg::*;

    logic [PKT_POS_W-1:0] pos_reg;
    logic [PKT_POS_W-1:0] pos_next;
    logic [PKT_SZ_W-1:0]  pkt_size;
    logic                 first;
    logic                 last;

    // accept only when the tables are ready and the queue has room
    assign s_ready = !clear_busy && !q_full;
    assign q_push  = s_valid && s_ready;

    // packet size held to 1..256
    always_comb begin
        if (packet_nodes == '0) begin
            pkt_size = PKT_SZ_W'(1);
        end else if (packet_nodes > PKT_SZ_MAX) begin
            pkt_size = PKT_SZ_MAX;
        end else begin
            pkt_size = packet_nodes;
        end
    end

    // packet boundary flags
    assign first    = (pos_reg == '0);
    assign last     = ({1'b0, pos_reg} >= (pkt_size - PKT_SZ_W'(1)));
    assign pos_next = last ? '0 : pos_reg + PKT_POS_W'(1);

    // classified queue entry
    always_comb begin
        q_data.action       = s_payload.action;
        q_data.in_range     = ({3'b000, s_payload.node_index} < 13'(NODE_COUNT));
        q_data.node_index   = s_payload.node_index;
        q_data.adc_reading  = s_payload.adc_reading;
        q_data.packet_first = first;
        q_data.packet_last  = last;
    end

    // packet position counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (q_push) begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ src/tncs_queue.sv @@
// two-entry queue between front and back
`timescale 1ns / 1ps
module tncs_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tncs_pkg::q_item_t push_data,
    output logic              full,
    input  logic              pop,
    output tncs_pkg::q_item_t head,
    output logic              empty
);
    import tncs_pkg::*;

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ src/tncs_back.sv @@
// back end: min/max tables, iterative divider and output register
`timescale 1ns / 1ps
module tncs_back #(
    parameter int NODE_COUNT = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              use_calibration,
    input  tncs_pkg::q_item_t q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              clear_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output tncs_pkg::out_item_t m_payload
);
    import tncs_pkg::*;

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    // sequencer states
    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_EVAL  = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    q_item_t             item_reg, item_next;
    logic [SAMPLE_W-1:0] val_reg, val_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] num_lo_reg, num_lo_next;
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic [SAMPLE_W-1:0] den_reg, den_next;
    logic [3:0]          step_reg, step_next;
    logic                m_valid_reg;
    out_item_t           m_payload_reg;

    logic [NODE_EXT_W-1:0] head_ext;
    logic [NODE_EXT_W-1:0] item_ext;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [SAMPLE_W-1:0]   max_rdata, min_rdata;
    logic                  max_we, min_we;
    logic [SAMPLE_W-1:0]   max_wdata, min_wdata;
    logic [SAMPLE_W-1:0]   mx, mn, clipped, diff;
    logic [PROD_W-1:0]     num;
    logic [SAMPLE_W:0]     trial;
    logic                  fits;
    logic                  out_load;

    // table addresses from the node index
    assign head_ext = NODE_EXT_W'(q_head.node_index);
    assign item_ext = NODE_EXT_W'(item_reg.node_index);
    assign raddr    = head_ext[AW-1:0];
    assign waddr    = (state_reg == B_CLEAR) ? clr_cnt_reg : item_ext[AW-1:0];

    assign clear_busy = (state_reg == B_CLEAR);
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;

    // table entries, zero outside the node range
    assign mx = item_reg.in_range ? max_rdata : '0;
    assign mn = item_reg.in_range ? min_rdata : '0;

    // clip to the node window and scale the offset by full scale
    always_comb begin
        clipped = item_reg.adc_reading;
        if (clipped < mn) begin
            clipped = mn;
        end
        if (clipped > mx) begin
            clipped = mx;
        end
    end
    assign diff = clipped - mn;
    assign num  = {1'b0, diff, 11'd0} + {2'b00, diff, 10'd0};

    // one restoring division step
    assign trial = {rem_reg, num_lo_reg[SAMPLE_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // table writes: clearing pass, then track and clear actions
    always_comb begin
        max_we    = 1'b0;
        min_we    = 1'b0;
        max_wdata = item_reg.adc_reading;
        min_wdata = item_reg.adc_reading;
        if (state_reg == B_CLEAR) begin
            max_we    = 1'b1;
            min_we    = 1'b1;
            max_wdata = '0;
            min_wdata = '0;
        end else if (state_reg == B_EVAL && item_reg.in_range) begin
            case (item_reg.action)
                ACT_TRACK_MAX: max_we = (item_reg.adc_reading > mx);
                ACT_TRACK_MIN: min_we = (item_reg.adc_reading < mn);
                ACT_CLEAR_MAX: begin
                    max_we    = 1'b1;
                    max_wdata = '0;
                end
                ACT_CLEAR_MIN: begin
                    min_we    = 1'b1;
                    min_wdata = FULL_SCALE;
                end
                default: begin
                end
            endcase
        end
    end

    assign out_load = (state_reg == B_OUT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        num_lo_next  = num_lo_reg;
        quo_next     = quo_reg;
        den_next     = den_reg;
        step_next    = step_reg;
        case (state_reg)
            B_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(NODE_COUNT - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    item_next  = q_head;
                    state_next = B_EVAL;
                end
            end
            B_EVAL: begin
                val_next   = item_reg.adc_reading;
                state_next = B_OUT;
                case (item_reg.action)
                    ACT_SCAN: begin
                        if (use_calibration) begin
                            if (mx > mn) begin
                                rem_next    = num[PROD_W-1:SAMPLE_W];
                                num_lo_next = num[SAMPLE_W-1:0];
                                den_next    = mx - mn;
                                quo_next    = '0;
                                step_next   = '0;
                                state_next  = B_DIV;
                            end else begin
                                val_next = '0;
                            end
                        end
                    end
                    ACT_CLEAR_MAX, ACT_CLEAR_MIN: val_next = '0;
                    default: begin
                    end
                endcase
            end
            B_DIV: begin
                rem_next    = fits ? SAMPLE_W'(trial - {1'b0, den_reg}) : trial[SAMPLE_W-1:0];
                num_lo_next = {num_lo_reg[SAMPLE_W-2:0], 1'b0};
                quo_next    = {quo_reg[SAMPLE_W-2:0], fits};
                step_next   = step_reg + 4'd1;
                if (step_reg == 4'(SAMPLE_W - 1)) begin
                    val_next   = {quo_reg[SAMPLE_W-2:0], fits};
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (out_load) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_cnt_reg <= '0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            step_reg    <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        num_lo_reg <= num_lo_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.pressure_value <= val_reg;
            m_payload_reg.packet_first   <= item_reg.packet_first;
            m_payload_reg.packet_last    <= item_reg.packet_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // per-node maximum table
    tncs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NODE_COUNT)
    ) u_max_table (
        .clk   (aclk),
        .we    (max_we),
        .waddr (waddr),
        .wdata (max_wdata),
        .raddr (raddr),
        .rdata (max_rdata)
    );

    // per-node minimum table
    tncs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NODE_COUNT)
    ) u_min_table (
        .clk   (aclk),
        .we    (min_we),
        .waddr (waddr),
        .wdata (min_wdata),
        .raddr (raddr),
        .rdata (min_rdata)
    );

endmodule
